// ===== rtl/core/humidity_temp_frame_check_convert_core_assert.svh =====
// assertion helpers for the core modules, used by the queue (htfc_fifo)
`ifndef HUMIDITY_TEMP_FRAME_CHECK_CONVERT_CORE_ASSERT_SVH
`define HUMIDITY_TEMP_FRAME_CHECK_CONVERT_CORE_ASSERT_SVH

// checked only outside reset
`define HTFC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked on every edge, reset included
`define HTFC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/htfc_pkg.sv =====
`timescale 1ns / 1ps
package htfc_pkg;

  localparam int HtfcQueueDepth = 2;

  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 17;
  localparam logic [CfgIdxW-1:0] CfgCrcPoly  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgTempCoef = 1'b1;

  localparam logic [7:0]         CrcPolyReset   = 8'h31;
  localparam logic signed [16:0] TempCoefReset  = -17'sd9830;

  localparam logic [14:0]        TempScale      = 15'd17572;
  localparam logic [14:0]        HumScale       = 15'd12500;
  localparam logic signed [32:0] TempOffset     = 33'sd307036160;
  localparam logic signed [32:0] HumOffset      = 33'sd39321600;
  localparam logic signed [20:0] TempErrValue   = 21'sd999900;
  localparam logic signed [20:0] HumErrValue    = 21'sd0;

  localparam logic signed [17:0] HumLimitHigh   = 18'sd10000;
  localparam logic signed [17:0] CompLow        = -18'sd2000;
  localparam logic signed [17:0] CompHigh       = 18'sd12000;
  localparam logic signed [21:0] TempRef        = 22'sd2500;
  localparam logic signed [20:0] TempCompHigh   = 21'sd8000;

  localparam logic KindTemp = 1'b0;
  localparam logic KindHum  = 1'b1;

  typedef struct packed {
    logic        kind;
    logic        crc_ok;
    logic [15:0] raw;
  } htfc_item_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data,
                                           input logic [7:0] poly);
    logic [7:0] c;
    c = crc_in ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ poly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/humidity_temp_frame_check_convert_core.sv =====
`timescale 1ns / 1ps
// the conversion engine pops the queue, then steps through multiply, convert,
// compensation multiply and output load, and pops no new frame until the output
// beat is loaded; the front takes a new input beat only in its idle state
// reset: synchronous active-low rst_n clears control, queue and latest readings,
// and loads the polynomial 0x31 and coefficient -9830
module humidity_temp_frame_check_convert_core
  import htfc_pkg::*;
#(
  parameter int QUEUE_DEPTH = HtfcQueueDepth
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [23:0]         in_tdata,   // msb_byte, lsb_byte, check_byte
  input  logic [0:0]          in_tuser,   // kind
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [39:0]         out_tdata,  // reading, compensated_humidity, zero pad
  output logic [0:0]          out_tuser   // crc_ok
);

  logic [7:0]         crc_poly_r;
  logic signed [16:0] temp_coef_r;
  logic               q_push, q_pop, q_full, q_empty;
  htfc_item_t         push_item, pop_item;
  logic               out_crc_ok;
  logic signed [20:0] out_reading;
  logic signed [14:0] out_comp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_poly_r  <= CrcPolyReset;
      temp_coef_r <= TempCoefReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgCrcPoly:  crc_poly_r  <= cfg_wdata[7:0];
        CfgTempCoef: temp_coef_r <= cfg_wdata[16:0];
        default: ;
      endcase
    end
  end

  htfc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .crc_poly (crc_poly_r),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_kind  (in_tuser[0]),
    .in_msb   (in_tdata[7:0]),
    .in_lsb   (in_tdata[15:8]),
    .in_chk   (in_tdata[23:16]),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (push_item)
  );

  htfc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .empty     (q_empty)
  );

  htfc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .temp_coef   (temp_coef_r),
    .q_empty     (q_empty),
    .q_item      (pop_item),
    .q_pop       (q_pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_crc_ok  (out_crc_ok),
    .out_reading (out_reading),
    .out_comp    (out_comp)
  );

  assign out_tdata = {4'b0000, out_comp, out_reading};
  assign out_tuser = out_crc_ok;

endmodule

// ===== rtl/core/htfc_front.sv =====
`timescale 1ns / 1ps
module htfc_front
  import htfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  crc_poly,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [7:0]  in_msb,
  input  logic [7:0]  in_lsb,
  input  logic [7:0]  in_chk,
  input  logic        q_full,
  output logic        q_push,
  output htfc_item_t  q_item
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_HI   = 2'd1;
  localparam logic [1:0] F_LO   = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       kind_r;
  logic [7:0] msb_r, lsb_r, chk_r, crc_r;
  logic [7:0] crc_final;

  assign in_ready  = (state_r == F_IDLE);
  assign crc_final = crc8_byte(crc_r, lsb_r, crc_poly);
  assign q_push    = (state_r == F_LO) && !q_full;

  always_comb begin
    q_item.kind   = kind_r;
    q_item.crc_ok = (crc_final == chk_r);
    q_item.raw    = {msb_r, lsb_r & 8'hFC};
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: if (in_valid) state_nxt = F_HI;
      F_HI:   state_nxt = F_LO;
      F_LO:   if (!q_full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      kind_r <= in_kind;
      msb_r  <= in_msb;
      lsb_r  <= in_lsb;
      chk_r  <= in_chk;
    end
    if (state_r == F_HI) begin
      crc_r <= crc8_byte(8'h00, msb_r, crc_poly);
    end
  end

endmodule

// ===== rtl/core/htfc_fifo.sv =====
`timescale 1ns / 1ps
`include "humidity_temp_frame_check_convert_core_assert.svh"
module htfc_fifo
  import htfc_pkg::*;
#(
  parameter int DEPTH = HtfcQueueDepth
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  htfc_item_t push_item,
  output logic       full,
  input  logic       pop,
  output htfc_item_t pop_item,
  output logic       empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  htfc_item_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_item = mem_r[rd_ptr_r];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_item;
  end

  `HTFC_ASSERT(a_no_push_full, push |-> !full, "push into a full queue")
  `HTFC_ASSERT(a_no_pop_empty, pop |-> !empty, "pop from an empty queue")
  `HTFC_ASSERT_RST(a_reset_empty, !rst_n |=> (count_r == '0), "queue not empty after reset")

endmodule

// ===== rtl/core/htfc_back.sv =====
`timescale 1ns / 1ps
module htfc_back
  import htfc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic signed [16:0]  temp_coef,
  input  logic                q_empty,
  input  htfc_item_t          q_item,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_crc_ok,
  output logic signed [20:0]  out_reading,
  output logic signed [14:0]  out_comp
);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_MUL  = 3'd1;
  localparam logic [2:0] B_CONV = 3'd2;
  localparam logic [2:0] B_COMP = 3'd3;
  localparam logic [2:0] B_OUT  = 3'd4;

  logic [2:0]         state_r, state_nxt;
  htfc_item_t         item_r;
  logic [31:0]        prod_r;
  logic signed [30:0] cprod_r;
  logic signed [20:0] reading_r;
  logic signed [20:0] last_temp_r;
  logic signed [14:0] last_hum_r;
  logic               out_valid_r;
  logic               out_crc_ok_r;
  logic signed [20:0] out_reading_r;
  logic signed [14:0] out_comp_r;

  logic               load_out;
  logic signed [32:0] conv_v;
  logic signed [32:0] conv_shift;
  logic signed [20:0] conv_reading;
  logic signed [21:0] diff_w;
  logic signed [13:0] diff;
  logic signed [30:0] adj_w;
  logic signed [17:0] h_ext, c_sum, comp_val;
  logic               t_in_range;

  assign q_pop    = (state_r == B_IDLE) && !q_empty;
  assign load_out = (state_r == B_OUT) && (!out_valid_r || out_ready);

  // raw conversion: floor((scale * raw - offset) / 65536), or the error value on a bad check byte
  always_comb begin
    conv_v       = $signed({1'b0, prod_r}) - ((item_r.kind == KindTemp) ? TempOffset : HumOffset);
    conv_shift   = conv_v >>> 16;
    conv_reading = conv_shift[20:0];
    if (!item_r.crc_ok) begin
      conv_reading = (item_r.kind == KindTemp) ? TempErrValue : HumErrValue;
    end
  end

  // compensation from latest readings
  always_comb begin
    diff_w     = TempRef - 22'(last_temp_r);
    diff       = diff_w[13:0];
    adj_w      = cprod_r >>> 16;
    h_ext      = 18'(last_hum_r);
    c_sum      = h_ext + adj_w[17:0];
    t_in_range = (last_temp_r > 21'sd0) && (last_temp_r < TempCompHigh);
    if (h_ext < 18'sd0) begin
      comp_val = '0;
    end else if (h_ext > HumLimitHigh) begin
      comp_val = HumLimitHigh;
    end else if (t_in_range) begin
      if (c_sum < CompLow) begin
        comp_val = CompLow;
      end else if (c_sum > CompHigh) begin
        comp_val = CompHigh;
      end else begin
        comp_val = c_sum;
      end
    end else begin
      comp_val = h_ext;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: if (!q_empty) state_nxt = B_MUL;
      B_MUL:  state_nxt = B_CONV;
      B_CONV: state_nxt = B_COMP;
      B_COMP: state_nxt = B_OUT;
      B_OUT:  if (load_out) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      last_temp_r <= '0;
      last_hum_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == B_CONV) begin
        if (item_r.kind == KindTemp) begin
          last_temp_r <= conv_reading;
        end else begin
          last_hum_r <= conv_reading[14:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) item_r <= q_item;
    if (state_r == B_MUL) begin
      prod_r <= 32'((item_r.kind == KindTemp) ? TempScale : HumScale) * 32'(item_r.raw);
    end
    if (state_r == B_CONV) reading_r <= conv_reading;
    if (state_r == B_COMP) cprod_r <= 31'(diff) * 31'(temp_coef);
    if (load_out) begin
      out_crc_ok_r  <= item_r.crc_ok;
      out_reading_r <= reading_r;
      out_comp_r    <= comp_val[14:0];
    end
  end

  assign out_valid   = out_valid_r;
  assign out_crc_ok  = out_crc_ok_r;
  assign out_reading = out_reading_r;
  assign out_comp    = out_comp_r;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import htfc_pkg::*;

  localparam int CycleLimit     = 1_000_000;
  localparam int TempFailValue  = 999900;
  localparam int HumFullScale   = 10000;
  localparam int CompFloor      = -2000;
  localparam int CompCeiling    = 12000;
  localparam int FramesPerPhase = 200;

  typedef struct {
    logic       kind;
    logic [7:0] msb;
    logic [7:0] lsb;
    logic [7:0] chk;
  } sensor_frame_t;

  typedef struct {
    logic               crc_ok;
    logic signed [20:0] reading;
    logic signed [14:0] comp;
  } frame_reading_t;

  logic                clk;
  logic                rst_n      = 1'b0;
  logic                cfg_we     = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index  = CfgCrcPoly;
  logic [CfgDataW-1:0] cfg_wdata  = '0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [23:0]         in_tdata   = '0;  // msb_byte, lsb_byte, check_byte
  logic [0:0]          in_tuser   = '0;  // kind
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [39:0]         out_tdata;        // reading, compensated_humidity, zero pad
  logic [0:0]          out_tuser;        // crc_ok

  sensor_frame_t  frames_to_send[$];
  frame_reading_t readings_due[$];
  sensor_frame_t  frame_on_bus;
  frame_reading_t want;

  // testbench copy of the block state and registers
  logic [7:0] sensor_poly = CrcPolyReset;
  int         temp_coef   = int'(TempCoefReset);
  int         latest_temp = 0;
  int         latest_hum  = 0;

  int  frames_queued   = 0;
  int  frames_sent     = 0;
  int  readings_seen   = 0;
  int  bad_crc_frames  = 0;
  int  clamped_results = 0;
  int  failures        = 0;
  int  cycles          = 0;
  int  send_gap        = 0;
  int  hold_gap        = 0;
  bit  no_idle         = 1'b0;

  humidity_temp_frame_check_convert_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // msb first, zero start, one data bit per step
  function automatic logic [7:0] crc8_word(input logic [7:0] poly, input logic [15:0] data);
    logic [7:0] c;
    c = 8'h00;
    for (int i = 15; i >= 0; i--) begin
      if (c[7] ^ data[i]) begin
        c = {c[6:0], 1'b0} ^ poly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic frame_reading_t convert_frame(input sensor_frame_t f);
    frame_reading_t r;
    longint raw;
    longint adj;
    int     value;
    raw = longint'({f.msb, f.lsb[7:2], 2'b00});
    r.crc_ok = (crc8_word(sensor_poly, {f.msb, f.lsb}) == f.chk);
    if (!r.crc_ok) begin
      bad_crc_frames++;
    end
    if (f.kind == KindTemp) begin
      value = r.crc_ok ? int'((17572 * raw - 4685 * 65536) >>> 16) : TempFailValue;
      latest_temp = value;
    end else begin
      value = r.crc_ok ? int'((12500 * raw - 600 * 65536) >>> 16) : 0;
      latest_hum = value;
    end
    r.reading = value[20:0];
    if (latest_hum < 0) begin
      adj = 0;
    end else if (latest_hum > HumFullScale) begin
      adj = longint'(HumFullScale);
    end else if (latest_temp > 0 && latest_temp < 8000) begin
      adj = longint'(latest_hum) + (((2500 - latest_temp) * longint'(temp_coef)) >>> 16);
      if (adj < CompFloor) begin
        adj = longint'(CompFloor);
        clamped_results++;
      end else if (adj > CompCeiling) begin
        adj = longint'(CompCeiling);
        clamped_results++;
      end
    end else begin
      adj = longint'(latest_hum);
    end
    r.comp = adj[14:0];
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (no_idle || r < 55) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // chk_err of zero gives a frame with a good check byte
  task automatic queue_frame(input logic kind, input logic [15:0] raw, input logic [7:0] chk_err);
    sensor_frame_t f;
    f.kind = kind;
    f.msb  = raw[15:8];
    f.lsb  = raw[7:0];
    f.chk  = crc8_word(sensor_poly, raw) ^ chk_err;
    frames_to_send.push_back(f);
    frames_queued++;
  endtask

  task automatic queue_random_frames(input int count);
    logic        kind;
    logic [15:0] raw;
    logic [7:0]  err;
    int          sel;
    for (int n = 0; n < count; n++) begin
      kind = 1'($urandom_range(1));
      sel  = $urandom_range(9);
      // bias toward the edges of the compensation window
      if (sel < 5) begin
        raw = 16'($urandom);
      end else if (kind == KindTemp) begin
        raw = (sel < 7) ? 16'($urandom_range(17460, 20000)) : 16'($urandom_range(45000, 47400));
      end else begin
        raw = (sel < 7) ? 16'($urandom_range(3130, 7000)) : 16'($urandom_range(51000, 55620));
      end
      sel = $urandom_range(19);
      if (sel == 0) begin
        err = 8'($urandom_range(1, 255));
      end else if (sel == 1) begin
        err = 8'h01 << $urandom_range(7);
      end else if (sel == 2) begin
        err = 8'hff;
      end else begin
        err = 8'h00;
      end
      queue_frame(kind, raw, err);
    end
  endtask

  task automatic wait_drained();
    while (frames_sent != frames_queued || readings_due.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic apply_setting(input logic [7:0] poly, input int coef);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CfgCrcPoly;
    cfg_wdata <= {9'($urandom), poly};
    @(posedge clk);
    cfg_index <= CfgTempCoef;
    cfg_wdata <= 17'(coef);
    @(posedge clk);
    cfg_we <= 1'b0;
    sensor_poly = poly;
    temp_coef   = coef;
  endtask

  task automatic flag_field(input string name, input logic signed [31:0] exp_val,
                            input logic signed [31:0] got_val);
    if (got_val !== exp_val) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, got_val);
      failures++;
    end
  endtask

  // input side
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        readings_due.push_back(convert_frame(frame_on_bus));
        frames_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (frames_to_send.size() > 0) begin
          frame_on_bus = frames_to_send.pop_front();
          in_tdata  <= {frame_on_bus.chk, frame_on_bus.lsb, frame_on_bus.msb};
          in_tuser  <= frame_on_bus.kind;
          in_tvalid <= 1'b1;
          send_gap = pick_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result side
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (readings_due.size() == 0) begin
          $display("%0t: result beat with nothing expected, reading %0d", $time,
                   $signed(out_tdata[20:0]));
          failures++;
        end else begin
          want = readings_due.pop_front();
          readings_seen++;
          flag_field("crc_ok", {31'd0, want.crc_ok}, {31'd0, out_tuser[0]});
          flag_field("reading", 32'(want.reading), 32'($signed(out_tdata[20:0])));
          flag_field("compensated_humidity", 32'(want.comp), 32'($signed(out_tdata[35:21])));
          flag_field("pad", 0, {28'd0, out_tdata[39:36]});
        end
      end
      if (hold_gap > 0) begin
        hold_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (!no_idle && $urandom_range(5) == 0) begin
          hold_gap = pick_gap();
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, readings_due.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    logic [7:0] poly;
    int         coef;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed frames at the reset register values
    queue_frame(KindTemp, 16'h0000, 8'h00);
    queue_frame(KindHum,  16'h0003, 8'h00);
    queue_frame(KindHum,  16'hffff, 8'h00);
    queue_frame(KindTemp, 16'hffff, 8'h00);
    queue_frame(KindHum,  16'h8000, 8'h00);
    queue_frame(KindTemp, 16'h4444, 8'h00);
    queue_frame(KindTemp, 16'h4448, 8'h00);
    queue_frame(KindTemp, 16'h444b, 8'h00);
    queue_frame(KindTemp, 16'hb8cc, 8'h00);
    queue_frame(KindTemp, 16'hb8d1, 8'h00);
    queue_frame(KindTemp, 16'h68ae, 8'h00);
    queue_frame(KindHum,  16'h0000, 8'h80);
    queue_frame(KindHum,  16'h8002, 8'h00);
    queue_frame(KindTemp, 16'h68ac, 8'hff);
    queue_frame(KindHum,  16'hc000, 8'h00);
    queue_frame(KindTemp, 16'h3000, 8'h01);
    queue_frame(KindTemp, 16'h68ad, 8'h00);
    queue_frame(KindHum,  16'hd916, 8'h00);
    queue_frame(KindHum,  16'hd91b, 8'h00);
    queue_frame(KindHum,  16'hd91c, 8'h00);
    queue_frame(KindHum,  16'h0c48, 8'h00);
    queue_frame(KindHum,  16'h0c4c, 8'h00);
    queue_frame(KindTemp, 16'h4448, 8'h00);
    queue_frame(KindHum,  16'hd91e, 8'h5a);
    wait_drained();

    for (int p = 0; p < 7; p++) begin
      case (p)
        0: begin poly = 8'h31; coef = -9830;  end
        1: begin poly = 8'h00; coef = -65536; end
        2: begin poly = 8'hff; coef = 65535;  end
        3: begin poly = 8'h07; coef = 0;      end
        default: begin
          poly = 8'($urandom_range(255));
          coef = int'($urandom_range(131071)) - 65536;
        end
      endcase
      apply_setting(poly, coef);
      no_idle = (p == 3);
      queue_random_frames(FramesPerPhase);
      wait_drained();
    end

    no_idle = 1'b0;
    repeat (20) @(posedge clk);
    $display("%0d frames checked under 8 register settings, polynomial and coefficient extremes",
             readings_seen);
    $display("%0d frames with a bad check byte, %0d compensated results saturated",
             bad_crc_frames, clamped_results);
    if (failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
